// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge except while reset is high
`define ICH_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("checksum block check failed");

// checked on every clock edge, reset included
`define ICH_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("checksum block check failed during reset");

`endif

// ===== rtl/ich_pkg.sv =====
package ich_pkg;

   localparam int BYTE_BITS = 8;
   localparam int MODE_BITS = 2;
   localparam int WORD_BITS = 16;
   localparam int SUM_BITS  = 32;

   // mode codes, read on the last beat only
   localparam logic [MODE_BITS-1:0] MODE_PLAIN     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_UDP       = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TCP       = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_PLAIN_ALT = 2'd3;

   localparam logic [SUM_BITS-1:0] PROTO_UDP      = 32'd17;
   localparam logic [SUM_BITS-1:0] PROTO_TCP      = 32'd6;
   localparam logic [SUM_BITS-1:0] PSEUDO_LEN_ADJ = 32'd8;

   // protocol number and length adjust merged into one offset (wraps mod 2^32)
   localparam logic [SUM_BITS-1:0] UDP_OFFSET = PROTO_UDP - PSEUDO_LEN_ADJ;
   localparam logic [SUM_BITS-1:0] TCP_OFFSET = PROTO_TCP - PSEUDO_LEN_ADJ;

   typedef logic [SUM_BITS-1:0]  sum_type;
   typedef logic [WORD_BITS-1:0] word_type;

endpackage

// ===== rtl/ich_req_if.sv =====
interface ich_req_if;
   logic                         valid;
   logic                         ready;
   logic [ich_pkg::BYTE_BITS-1:0] data_byte;
   logic                         last;
   logic [ich_pkg::MODE_BITS-1:0] mode;

   modport source (output valid, output data_byte, output last, output mode, input ready);
   modport sink   (input valid, input data_byte, input last, input mode, output ready);
endinterface

// ===== rtl/ich_rsp_if.sv =====
interface ich_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ich_pkg::WORD_BITS-1:0] checksum_value;

   modport source (output valid, output checksum_value, input ready);
   modport sink   (input valid, input checksum_value, output ready);
endinterface

// ===== rtl/internet_checksum_pseudo_header.sv =====
// internet checksum with optional udp/tcp pseudo-header terms
//
// req_if: one byte of the checksummed region per beat, with last and mode.
//    bytes pair big-endian into 16-bit words; an odd final byte is the high
//    byte of a word. mode is looked at only on the last beat.
// rsp_if: one checksum_value beat for every last beat, nothing otherwise.
//
// throughput: one byte per cycle, back to back, while no last beat is held up by
//    the later stages; set by the single 32-bit accumulate in the input stage.
// path: a last beat accepted on req_if passes the input stage, the sum stage and
//    the result register in turn before its checksum shows on rsp_if.
//
// reset (synchronous, active high) empties all stages and clears the running
//    sum, byte count and pending high byte.
// when the receiver stalls, the result register holds and the sum stage keeps
//    one more finished sum; non-last bytes still flow into the accumulator.
//    only a last beat that finds both later stages full stops req_if.ready.
module internet_checksum_pseudo_header #(
   parameter int COUNT_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ich_req_if.sink    req_if,
   ich_rsp_if.source  rsp_if
);

   localparam int PAD_BITS = ich_pkg::SUM_BITS - COUNT_BITS;

   // input stage
   logic                          in_valid_ff, in_valid_in;
   logic [ich_pkg::BYTE_BITS-1:0] in_byte_ff;
   logic                          in_last_ff;
   logic [ich_pkg::MODE_BITS-1:0] in_mode_ff;

   // accumulator state
   ich_pkg::sum_type              sum_ff, sum_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [ich_pkg::BYTE_BITS-1:0] hold_ff, hold_in;
   logic                          hold_valid_ff, hold_valid_in;

   // sum stage
   logic                          fin_valid_ff, fin_valid_in;
   ich_pkg::sum_type              fin_sum_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   ich_pkg::word_type             rsp_value_ff;

   logic                          out_free;
   logic                          fin_free;
   logic                          in_advance;
   logic                          req_take;
   logic [COUNT_BITS-1:0]         count_next;
   ich_pkg::word_type             word;
   ich_pkg::sum_type              pseudo_term;
   ich_pkg::sum_type              final_sum;
   logic [ich_pkg::WORD_BITS:0]   fold_one;
   ich_pkg::word_type             fold_two;

   // handshake chain, back to front
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign fin_free   = !fin_valid_ff || out_free;
   assign in_advance = in_valid_ff && (!in_last_ff || fin_free);
   assign req_if.ready = !in_valid_ff || in_advance;
   assign req_take   = req_if.valid && req_if.ready;

   assign count_next = count_ff + 1'b1;

   // a pending high byte pairs with this one; otherwise this byte is the high half
   assign word = hold_valid_ff ? {hold_ff, in_byte_ff} : {in_byte_ff, 8'h00};

   always_comb begin
      case (in_mode_ff)
         ich_pkg::MODE_UDP: begin
            pseudo_term = {{PAD_BITS{1'b0}}, count_next} + ich_pkg::UDP_OFFSET;
         end
         ich_pkg::MODE_TCP: begin
            pseudo_term = {{PAD_BITS{1'b0}}, count_next} + ich_pkg::TCP_OFFSET;
         end
         ich_pkg::MODE_PLAIN, ich_pkg::MODE_PLAIN_ALT: begin
            pseudo_term = '0;
         end
         default: begin
            pseudo_term = '0;
         end
      endcase
   end

   // on the last byte the word (paired or odd) always goes into the total
   assign final_sum = sum_ff + {16'h0000, word} + pseudo_term;

   // accumulator update, cleared after a last byte
   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (in_advance) begin
         if (in_last_ff) begin
            sum_in        = '0;
            count_in      = '0;
            hold_in       = '0;
            hold_valid_in = 1'b0;
         end else if (hold_valid_ff) begin
            sum_in        = sum_ff + {16'h0000, word};
            count_in      = count_next;
            hold_in       = '0;
            hold_valid_in = 1'b0;
         end else begin
            count_in      = count_next;
            hold_in       = in_byte_ff;
            hold_valid_in = 1'b1;
         end
      end
   end

   // two end-around folds bring any 32-bit sum into 16 bits
   assign fold_one = {1'b0, fin_sum_ff[15:0]} + {1'b0, fin_sum_ff[31:16]};
   assign fold_two = fold_one[15:0] + {15'h0000, fold_one[16]};

   assign in_valid_in  = req_take ? 1'b1 : (in_advance ? 1'b0 : in_valid_ff);
   assign fin_valid_in = (in_advance && in_last_ff) ? 1'b1 :
                         (out_free ? 1'b0 : fin_valid_ff);
   assign rsp_valid_in = out_free ? fin_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         fin_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         hold_ff       <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         fin_valid_ff  <= fin_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         hold_ff       <= hold_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.last;
         in_mode_ff <= req_if.mode;
      end
      if (in_advance && in_last_ff) begin
         fin_sum_ff <= final_sum;
      end
      if (out_free && fin_valid_ff) begin
         rsp_value_ff <= ~fold_two;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.checksum_value = rsp_value_ff;

endmodule

// ===== rtl/ich_checker.sv =====
`include "assert_macros.svh"

module ich_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_checksum_value
);

   // a stalled result holds its value
   `ICH_ASSERT(rsp_hold_chk, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_checksum_value))

   // a result only leaves through a handshake
   `ICH_ASSERT(rsp_drop_chk, $fell(rsp_valid) |-> $past(rsp_ready))

   // input back-pressure only comes from a stalled result
   `ICH_ASSERT(req_stall_chk, !req_ready |-> rsp_valid && !rsp_ready)

   // reset empties the result register
   `ICH_ASSERT_ALWAYS(rsp_reset_chk, reset |=> !rsp_valid)

endmodule

bind internet_checksum_pseudo_header ich_checker u_ich_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_checksum_value (rsp_if.checksum_value)
);

// ===== dv/internet_checksum_pseudo_header_tb.sv =====
module internet_checksum_pseudo_header_tb;

   localparam int COUNT_W       = 16;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int DRAIN_CYCLES  = 10;       // extra edges after the drain to catch stray results
   localparam int HOLD_CYCLES   = 300;      // long receiver hold-off, fills the pipe
   localparam int RANDOM_BEATS  = 430;
   localparam int RANDOM_REGIONS = 50;
   localparam int REPORT_MAX    = 10;
   localparam int DIRECTED_ROWS = 23;

   typedef logic [ich_pkg::BYTE_BITS-1:0] byte_type;
   typedef logic [ich_pkg::MODE_BITS-1:0] mode_type;

   logic clock;
   logic reset;

   ich_req_if req_bus ();
   ich_rsp_if rsp_bus ();

   internet_checksum_pseudo_header #(.COUNT_BITS(COUNT_W)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // one row of the directed table; csum is only used when fixed is set
   typedef struct {
      byte_type          data;
      logic              last;
      mode_type          mode;
      bit                fixed;
      ich_pkg::word_type csum;
   } stim_row_type;

   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, ich_pkg::MODE_PLAIN,     1'b1, 16'hFFFF},   // zero byte right after reset
      '{8'hFF, 1'b1, ich_pkg::MODE_PLAIN,     1'b1, 16'h00FF},   // lone byte is the high byte
      '{8'hFF, 1'b0, ich_pkg::MODE_PLAIN_ALT, 1'b0, 16'h0000},   // mode ignored when not last
      '{8'hFF, 1'b1, ich_pkg::MODE_PLAIN,     1'b1, 16'h0000},   // all-ones word
      '{8'h00, 1'b1, ich_pkg::MODE_UDP,       1'b1, 16'hFFF5},   // short region, count-8 wraps
      '{8'h00, 1'b1, ich_pkg::MODE_TCP,       1'b1, 16'h0000},   // same wrap, tcp offset
      '{8'hFF, 1'b1, ich_pkg::MODE_PLAIN_ALT, 1'b1, 16'h00FF},   // mode three acts as plain
      // eight-byte udp region, length term exactly zero
      '{8'h12, 1'b0, ich_pkg::MODE_TCP,       1'b0, 16'h0000},
      '{8'h34, 1'b0, ich_pkg::MODE_UDP,       1'b0, 16'h0000},
      '{8'h56, 1'b0, ich_pkg::MODE_PLAIN,     1'b0, 16'h0000},
      '{8'h78, 1'b0, ich_pkg::MODE_PLAIN_ALT, 1'b0, 16'h0000},
      '{8'h9A, 1'b0, ich_pkg::MODE_TCP,       1'b0, 16'h0000},
      '{8'hBC, 1'b0, ich_pkg::MODE_UDP,       1'b0, 16'h0000},
      '{8'hDE, 1'b0, ich_pkg::MODE_TCP,       1'b0, 16'h0000},
      '{8'hF0, 1'b1, ich_pkg::MODE_UDP,       1'b0, 16'h0000},
      // odd-length tcp region
      '{8'hAB, 1'b0, ich_pkg::MODE_UDP,       1'b0, 16'h0000},
      '{8'hCD, 1'b0, ich_pkg::MODE_TCP,       1'b0, 16'h0000},
      '{8'hEF, 1'b1, ich_pkg::MODE_TCP,       1'b0, 16'h0000},
      // two words that sum to all ones with no carry, plain alt
      '{8'h80, 1'b0, ich_pkg::MODE_UDP,       1'b0, 16'h0000},
      '{8'h01, 1'b0, ich_pkg::MODE_TCP,       1'b0, 16'h0000},
      '{8'h7F, 1'b0, ich_pkg::MODE_PLAIN,     1'b0, 16'h0000},
      '{8'hFE, 1'b1, ich_pkg::MODE_PLAIN_ALT, 1'b0, 16'h0000},
      '{8'h01, 1'b1, ich_pkg::MODE_UDP,       1'b0, 16'h0000}    // single byte udp
   };

   // predictor state, mirrors the block
   ich_pkg::sum_type     acc_sum;
   logic [COUNT_W-1:0]   seen_count;
   byte_type             held_byte;
   logic                 held_valid;

   // checksums still owed by the block, oldest first
   ich_pkg::word_type pending_checksums [$];

   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned beats_sent;
   int unsigned checksums_checked;
   int unsigned regions_by_mode [4];
   int unsigned longest_region;

   // pressure handshake between sender and receiver processes
   bit hold_request;
   bit hold_done;

   // clock and a single reset at the start
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d checksums outstanding",
                  cycle_count, pending_checksums.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else return $urandom_range(11, 40);
   endfunction

   // byte values leaning toward the extremes
   function automatic byte_type pick_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 8'h00;
      else if (r < 30) return 8'hFF;
      else return byte_type'($urandom_range(0, 255));
   endfunction

   // end-around-carry fold, then ones' complement
   function automatic ich_pkg::word_type fold_and_invert(input ich_pkg::sum_type s);
      ich_pkg::sum_type f;
      f = s;
      while (f[31:16] != 16'h0000)
         f = {16'h0000, f[15:0]} + {16'h0000, f[31:16]};
      return ~f[15:0];
   endfunction

   // advance the predictor by one beat; done is set when a checksum falls out
   task automatic absorb_byte(input byte_type d, input logic l,
                              input mode_type m,
                              output bit done, output ich_pkg::word_type csum);
      ich_pkg::sum_type s;
      done = 1'b0;
      csum = '0;
      seen_count = seen_count + 1'b1;
      // big-endian pairing: first byte of a word is held until its partner
      if (held_valid) begin
         acc_sum    = acc_sum + {16'h0000, held_byte, d};
         held_valid = 1'b0;
         held_byte  = '0;
      end else begin
         held_byte  = d;
         held_valid = 1'b1;
      end
      if (l) begin
         s = acc_sum;
         // odd final byte is padded as the high byte
         if (held_valid)
            s = s + {16'h0000, held_byte, 8'h00};
         // pseudo-header terms, length term wraps mod 2^32 on short regions
         if (m == ich_pkg::MODE_UDP) begin
            s = s + ich_pkg::PROTO_UDP;
            s = s + (ich_pkg::sum_type'(seen_count) - ich_pkg::PSEUDO_LEN_ADJ);
         end else if (m == ich_pkg::MODE_TCP) begin
            s = s + ich_pkg::PROTO_TCP;
            s = s + (ich_pkg::sum_type'(seen_count) - ich_pkg::PSEUDO_LEN_ADJ);
         end
         csum       = fold_and_invert(s);
         done       = 1'b1;
         acc_sum    = '0;
         seen_count = '0;
         held_byte  = '0;
         held_valid = 1'b0;
      end
   endtask

   // offer one beat, wait for the handshake, then idle for the given gap
   task automatic send_beat(input byte_type d, input logic l,
                            input mode_type m, input int unsigned gap,
                            input bit use_fixed, input ich_pkg::word_type fixed_csum);
      bit                done;
      ich_pkg::word_type csum;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.last      <= l;
      req_bus.mode      <= m;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb_byte(d, l, m, done, csum);
      beats_sent++;
      if (done) pending_checksums.push_back(use_fixed ? fixed_csum : csum);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one random region; no_idle gives a back-to-back burst
   task automatic send_region(input int unsigned len, input mode_type m,
                              input bit no_idle);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         send_beat(pick_byte(), i == len - 1,
                   (i == len - 1) ? m : mode_type'($urandom_range(0, 3)),
                   no_idle ? 0 : pick_idle_len(), 1'b0, '0);
      end
      regions_by_mode[m]++;
      if (len > longest_region) longest_region = len;
   endtask

   task automatic note_mismatch(input string what, input ich_pkg::word_type exp_v,
                                input ich_pkg::word_type act_v);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch %0d (%s): expected %04h actual %04h at cycle %0d",
                  mismatches, what, exp_v, act_v, cycle_count);
   endtask

   // result checker, compares against the oldest outstanding checksum
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_checksums.size() == 0) begin
            note_mismatch("unexpected beat", '0, rsp_bus.checksum_value);
         end else begin
            ich_pkg::word_type exp_v;
            exp_v = pending_checksums.pop_front();
            checksums_checked++;
            if (rsp_bus.checksum_value !== exp_v)
               note_mismatch("checksum_value", exp_v, rsp_bus.checksum_value);
         end
      end
   end

   // receiver: random ready stretches, plus one long hold-off on request
   initial begin
      int unsigned run_len;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            // count the hold in cycles here while the sender keeps pushing
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            // ready stretch, sometimes long enough to be stall-free
            run_len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                   : $urandom_range(20, 60);
            rsp_bus.ready <= 1'b1;
            repeat (run_len) @(posedge clock);
            run_len = pick_idle_len();
            if (run_len != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (run_len) @(posedge clock);
            end
         end
      end
   end

   // sender: directed table, then random regions
   initial begin
      int unsigned row;
      int unsigned random_beats;
      int unsigned random_regions;
      int unsigned len;
      int unsigned r;
      int unsigned i;
      bit          burst;

      acc_sum     = '0;
      seen_count  = '0;
      held_byte   = '0;
      held_valid  = 1'b0;
      beats_sent  = 0;
      longest_region = 0;
      for (i = 0; i < 4; i++) regions_by_mode[i] = 0;
      hold_request = 1'b0;
      hold_done    = 1'b0;
      random_beats   = 0;
      random_regions = 0;

      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last      <= 1'b0;
      req_bus.mode      <= ich_pkg::MODE_PLAIN;
      @(negedge reset);
      @(posedge clock);

      // directed rows, fixed checksums where typed in
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_beat(directed_table[row].data, directed_table[row].last,
                   directed_table[row].mode, pick_idle_len(),
                   directed_table[row].fixed, directed_table[row].csum);
         if (directed_table[row].last) regions_by_mode[directed_table[row].mode]++;
      end

      // random regions: mostly short so results come often, a few longer ones
      while (random_beats < RANDOM_BEATS || random_regions < RANDOM_REGIONS) begin
         r = $urandom_range(0, 99);
         if (r < 65) len = $urandom_range(1, 6);
         else if (r < 92) len = $urandom_range(7, 16);
         else len = $urandom_range(17, 64);
         burst = ($urandom_range(0, 99) < 30);
         // partway in, ask the receiver for its long hold-off
         if (random_regions == 10) hold_request = 1'b1;
         send_region(len, mode_type'($urandom_range(0, 3)), burst);
         random_beats   += len;
         random_regions++;
      end

      req_bus.valid <= 1'b0;

      // drain, then a few more edges to catch stray beats
      while (pending_checksums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d beats: %0d plain, %0d udp, %0d tcp, %0d mode-three regions",
               beats_sent, regions_by_mode[ich_pkg::MODE_PLAIN],
               regions_by_mode[ich_pkg::MODE_UDP], regions_by_mode[ich_pkg::MODE_TCP],
               regions_by_mode[ich_pkg::MODE_PLAIN_ALT]);
      $display("checked %0d checksums, longest region %0d bytes, %0d mismatches",
               checksums_checked, longest_region, mismatches);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
